// ----- sv/e2q_pkg.sv -----
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants and types for the Euler to quaternion converter
// Holds fixed-point widths, polynomial divisors and the pipeline payload type.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int QW                = 32;          // Q30 magnitude width, x squared reaches ~2.47
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [QW-1:0] Q30_ONE   = 32'h4000_0000;
    localparam int NSTEP             = 5;

    // polynomial divisors, one per series step
    function automatic logic [7:0] sin_div(input int k);
        logic [7:0] d;
        unique case (k)
            0: d = 8'd110;
            1: d = 8'd72;
            2: d = 8'd42;
            3: d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] cos_div(input int k);
        logic [7:0] d;
        unique case (k)
            0: d = 8'd132;
            1: d = 8'd90;
            2: d = 8'd56;
            3: d = 8'd30;
            default: d = 8'd12;
        endcase
        return d;
    endfunction

    // Q30 product, truncated
    function automatic logic [QW-1:0] mulq(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [2*QW-1:0] p;
        p = a * b;
        return p[QW+29:30];
    endfunction

    // signed magnitude value carried through the cells
    typedef struct packed {
        logic           neg;
        logic [QW-1:0]  mag;
    } t_sval;

endpackage

// ----- sv/e2q_cell.sv -----
// ----------------------------------------------------------------------------
// e2q_cell: one step of the half-angle sine and cosine series
// Two registered stages; evaluates f = 1 - mul(x2,f)/k for sine and cosine.
// ----------------------------------------------------------------------------
module e2q_cell #(
    parameter logic [7:0] SDIV = 8'd110,
    parameter logic [7:0] CDIV = 8'd132
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [e2q_pkg::QW-1:0]  i_x,
    input  logic [e2q_pkg::QW-1:0]  i_x2,
    input  logic [e2q_pkg::QW-1:0]  i_fs,
    input  logic [e2q_pkg::QW-1:0]  i_fc,
    input  logic [1:0]              i_quad,
    output logic [e2q_pkg::QW-1:0]  o_x,
    output logic [e2q_pkg::QW-1:0]  o_x2,
    output logic [e2q_pkg::QW-1:0]  o_fs,
    output logic [e2q_pkg::QW-1:0]  o_fc,
    output logic [1:0]              o_quad
);
    localparam int QW = e2q_pkg::QW;
    // reciprocals: floor(n/k) = (n * ceil(2^s/k)) >> s for every QW-bit n
    localparam int SSH = QW + $clog2(SDIV);
    localparam int CSH = QW + $clog2(CDIV);
    localparam logic [QW:0] SREC =
        (QW+1)'(((64'd1 << SSH) + 64'(SDIV) - 64'd1) / 64'(SDIV));
    localparam logic [QW:0] CREC =
        (QW+1)'(((64'd1 << CSH) + 64'(CDIV) - 64'd1) / 64'(CDIV));

    logic [QW-1:0] r_xa, r_x2a, r_ps, r_pc;
    logic [1:0]    r_qa;
    logic [QW-1:0] r_x, r_x2, r_fs, r_fc;
    logic [1:0]    r_quad;
    logic [2*QW:0] w_qs, w_qc;
    logic [QW-1:0] n_fs, n_fc;

    // divide the products by the constants and finish the step
    always_comb begin
        w_qs = r_ps * SREC;
        w_qc = r_pc * CREC;
        n_fs = e2q_pkg::Q30_ONE - QW'(w_qs >> SSH);
        n_fc = e2q_pkg::Q30_ONE - QW'(w_qc >> CSH);
    end

    // advance when the pipeline moves: products first, then the step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xa   <= i_x;
            r_x2a  <= i_x2;
            r_qa   <= i_quad;
            r_ps   <= e2q_pkg::mulq(i_x2, i_fs);
            r_pc   <= e2q_pkg::mulq(i_x2, i_fc);
            r_x    <= r_xa;
            r_x2   <= r_x2a;
            r_quad <= r_qa;
            r_fs   <= n_fs;
            r_fc   <= n_fc;
        end
    end

    assign o_x = r_x;
    assign o_x2 = r_x2;
    assign o_fs = r_fs;
    assign o_fc = r_fc;
    assign o_quad = r_quad;
endmodule

// ----- sv/e2q_sincos.sv -----
// ----------------------------------------------------------------------------
// e2q_sincos: half-angle sine and cosine through a chain of series cells
// Phase, x and x squared in three stages, five two-stage cells, then a
// finishing stage.
// ----------------------------------------------------------------------------
module e2q_sincos #(
    parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [ANGLE_BITS-1:0]  i_angle,
    output e2q_pkg::t_sval         o_sin,
    output e2q_pkg::t_sval         o_cos
);
    localparam int QW = e2q_pkg::QW;
    localparam int NS = e2q_pkg::NSTEP;

    logic [63:0]   w_ph;
    logic [31:0]   w_phase;
    logic [29:0]   r_t;
    logic [1:0]    r_q0, r_q1, r_q2;
    logic [QW-1:0] r_x, r_xa, r_x2;
    logic [61:0]   w_tx;
    logic [QW-1:0] c_x [0:NS];
    logic [QW-1:0] c_x2[0:NS];
    logic [QW-1:0] c_fs[0:NS];
    logic [QW-1:0] c_fc[0:NS];
    logic [1:0]    c_q [0:NS];
    logic [QW-1:0] n_sv, n_cv, w_d;
    e2q_pkg::t_sval r_sin, r_cos;

    // half angle as 32-bit phase
    assign w_ph = 64'(i_angle) << (63 - ANGLE_BITS);
    assign w_phase = w_ph[63:32];
    assign w_tx = r_t * e2q_pkg::HALF_PI_Q30;

    // stage one: phase split; stage two: x; stage three: x squared
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t  <= w_phase[29:0];
            r_q0 <= w_phase[31:30];
            r_x  <= w_tx[61:30];
            r_q1 <= r_q0;
            r_xa <= r_x;
            r_x2 <= e2q_pkg::mulq(r_x, r_x);
            r_q2 <= r_q1;
        end
    end

    assign c_x[0] = r_xa;
    assign c_x2[0] = r_x2;
    assign c_fs[0] = e2q_pkg::Q30_ONE;
    assign c_fc[0] = e2q_pkg::Q30_ONE;
    assign c_q[0] = r_q2;

    // chain of series cells
    for (genvar k = 0; k < NS; k++) begin : g_cell
        e2q_cell #(
            .SDIV(e2q_pkg::sin_div(k)),
            .CDIV(e2q_pkg::cos_div(k))
        ) u_cell (
            .i_clk(i_clk), .i_en(i_en),
            .i_x(c_x[k]), .i_x2(c_x2[k]), .i_fs(c_fs[k]), .i_fc(c_fc[k]),
            .i_quad(c_q[k]),
            .o_x(c_x[k+1]), .o_x2(c_x2[k+1]), .o_fs(c_fs[k+1]), .o_fc(c_fc[k+1]),
            .o_quad(c_q[k+1])
        );
    end

    // finish values and map quadrant
    always_comb begin
        n_sv = e2q_pkg::mulq(c_x[NS], c_fs[NS]);
        if (n_sv > e2q_pkg::Q30_ONE) begin
            n_sv = e2q_pkg::Q30_ONE;
        end
        w_d = e2q_pkg::mulq(c_x2[NS], c_fc[NS]) >> 1;
        n_cv = (w_d >= e2q_pkg::Q30_ONE) ? '0 : e2q_pkg::Q30_ONE - w_d;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (c_q[NS])
                2'd0: begin r_sin <= '{1'b0, n_sv}; r_cos <= '{1'b0, n_cv}; end
                2'd1: begin r_sin <= '{1'b0, n_cv}; r_cos <= '{1'b1, n_sv}; end
                2'd2: begin r_sin <= '{1'b1, n_sv}; r_cos <= '{1'b1, n_cv}; end
                default: begin r_sin <= '{1'b1, n_cv}; r_cos <= '{1'b0, n_sv}; end
            endcase
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

// ----- sv/euler_to_quaternion_top.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion_top: binary Euler angles to a unit quaternion
// Three half-angle sine/cosine chains feed a product, sum and rounding pipe.
// ----------------------------------------------------------------------------
// Usage: s_axis tdata carries angle_x, angle_y, angle_z (bits 15:0, 31:16,
// 47:32). m_axis tdata carries quat_w, quat_x, quat_y, quat_z in Q2.14.
// i_cfg_we with i_cfg_wdata[0] writes compose_mode (0 full, 1 yaw-pitch);
// write it only while idle.
// Throughput: one transaction per cycle unless the output stalls.
// Pipeline: an accepted input passes 14 register stages in the
// sine/cosine cell chain (the first at the accepting edge), 2 for
// the two product multiplies, then sum and rounding into the output
// register. The whole pipe advances together; when the receiver stalls
// with a valid output held, the pipe freezes and s_axis_tready drops.
// Reset clears all valid flags and compose_mode; payload is not reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion_top #(
    parameter int ANGLE_BITS    = e2q_pkg::ANGLE_BITS_DEF,
    parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // angle_x, angle_y, angle_z from the lowest bit, zero filled to bytes
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from the lowest bit, zero filled
    output logic [((4*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
    localparam int QW = e2q_pkg::QW;
    localparam int OW = OUT_FRAC_BITS + 2;
    localparam int LAT = 16;
    localparam int SH = 30 - OUT_FRAC_BITS;

    logic              r_mode;
    logic [LAT-1:0]    r_vld;
    logic              w_en;
    e2q_pkg::t_sval    w_s[3], w_c[3];
    e2q_pkg::t_sval    w_a[8], w_b[8], w_cc[8];
    logic [QW-1:0]     r_p1[8], r_p2[8];
    logic [QW-1:0]     r_pc[8];
    logic [7:0]        r_n1, r_n2;
    logic [LAT-1:0]    r_md;
    logic [OW-1:0]     n_q[4];
    logic [OW-1:0]     r_q[4];
    logic              r_ov;

    // pipe advances unless the output is held
    assign w_en = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    for (genvar g = 0; g < 3; g++) begin : g_sc
        e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc (
            .i_clk(i_clk), .i_en(w_en),
            .i_angle(s_axis_tdata[g*ANGLE_BITS +: ANGLE_BITS]),
            .o_sin(w_s[g]), .o_cos(w_c[g])
        );
    end

    // terms: pair k gives (a,b,c); h=0, b=1, c=2
    // mode 1: the first term of each pair gives w=cc cb, x=sc sb, y=sc cb,
    // z=cc sb with a set to one; the second term is dropped in the sum
    always_comb begin
        w_a[0] = w_c[0]; w_b[0] = w_c[2]; w_cc[0] = w_c[1];
        w_a[1] = w_s[0]; w_b[1] = w_s[2]; w_cc[1] = w_s[1];
        w_a[2] = w_s[0]; w_b[2] = w_c[2]; w_cc[2] = w_c[1];
        w_a[3] = w_c[0]; w_b[3] = w_s[2]; w_cc[3] = w_s[1];
        w_a[4] = w_c[0]; w_b[4] = w_s[2]; w_cc[4] = w_c[1];
        w_a[5] = w_s[0]; w_b[5] = w_c[2]; w_cc[5] = w_s[1];
        w_a[6] = w_c[0]; w_b[6] = w_c[2]; w_cc[6] = w_s[1];
        w_a[7] = w_s[0]; w_b[7] = w_s[2]; w_cc[7] = w_c[1];
        if (r_md[LAT-3]) begin
            for (int k = 0; k < 8; k++) begin
                w_a[k] = '{1'b0, e2q_pkg::Q30_ONE};
            end
            w_b[2] = w_s[2]; w_cc[2] = w_s[1];
        end
    end

    // two product stages, one multiply each
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 8; k++) begin
                r_p1[k] <= e2q_pkg::mulq(w_a[k].mag, w_b[k].mag);
                r_pc[k] <= w_cc[k].mag;
                r_n1[k] <= w_a[k].neg ^ w_b[k].neg ^ w_cc[k].neg;
                r_p2[k] <= e2q_pkg::mulq(r_p1[k], r_pc[k]);
            end
            r_n2 <= r_n1;
        end
    end

    // sum pairs and round
    always_comb begin
        logic signed [QW+2:0] v;
        logic [QW+1:0]        m;
        logic [QW+1:0]        lim;
        lim = (QW+2)'(1) << OUT_FRAC_BITS;
        for (int j = 0; j < 4; j++) begin
            v = r_n2[2*j] ? -$signed({3'b0, r_p2[2*j]}) : $signed({3'b0, r_p2[2*j]});
            if (!r_md[LAT-1]) begin
                if (r_n2[2*j+1] ^ (j == 1 || j == 3)) begin
                    v = v - $signed({3'b0, r_p2[2*j+1]});
                end else begin
                    v = v + $signed({3'b0, r_p2[2*j+1]});
                end
            end
            m = v[QW+2] ? (QW+2)'(-v) : v[QW+1:0];
            m = (m + (((QW+2)'(1) << SH) >> 1)) >> SH;
            if (m > lim) begin
                m = lim;
            end
            n_q[j] = v[QW+2] ? OW'(-m) : m[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_vld  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
                r_ov  <= r_vld[LAT-1];
            end
        end
    end

    // mode travels with the data
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_md <= {r_md[LAT-2:0], r_mode};
            for (int j = 0; j < 4; j++) begin
                r_q[j] <= n_q[j];
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    always_comb begin
        m_axis_tdata = '0;
        for (int j = 0; j < 4; j++) begin
            m_axis_tdata[j*OW +: OW] = r_q[j];
        end
    end

    // output must not vanish while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov)
        else $error("output lost under stall");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov |-> s_axis_tready)
        else $error("input blocked while output empty");
    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipe moved while frozen");
endmodule
